// ===== rtl/core/lfd_pkg.sv =====
`timescale 1ns / 1ps

package lfd_pkg;

    // default for the largest frame the design is built for
    localparam int FRAME_LIMIT_DEF = 4096;

    localparam int CFG_W    = 13;
    localparam int INDEX_W  = 12;
    localparam int LENGTH_W = 32;

    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 13'd4096;

    // request kinds
    localparam logic REQ_BYTE      = 1'b0;
    localparam logic REQ_LINK_LOST = 1'b1;

    // frame type codes
    localparam logic [7:0] TYPE_INPUT    = 8'h01;
    localparam logic [7:0] TYPE_PAD_INFO = 8'h03;
    localparam logic [7:0] TYPE_PAD_GONE = 8'h04;
    localparam logic [7:0] TYPE_CALIB    = 8'h06;

    // payload lengths that decide the report
    localparam logic [LENGTH_W-1:0] INPUT_REPORT_LEN = 32'd64;
    localparam logic [LENGTH_W-1:0] PAD_INFO_MIN_LEN = 32'd7;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_TYPE,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_INPUT,
        EV_BAD_INPUT,
        EV_PAD_INFO,
        EV_PAD_GONE,
        EV_CALIB,
        EV_IGNORED,
        EV_BAD_LEN
    } t_event;

    typedef struct packed {
        logic                payload_valid;
        logic [7:0]          payload_byte;
        logic [INDEX_W-1:0]  payload_index;
        logic [7:0]          frame_type;
        logic                frame_end;
        t_event              event_code;
        logic                pad_present;
        logic [LENGTH_W-1:0] frame_length;
    } t_result;

endpackage

// ===== rtl/core/length_prefixed_frame_deframer_top.sv =====
`timescale 1ns / 1ps

// Length-prefixed frame deframer. Takes one request per cycle on the input
// channel while o_ready is high, either a received stream byte or a link-lost
// event, and returns exactly one result per request, in order. A frame is a
// 32-bit little-endian length L (type byte plus payload), a type byte, then
// L-1 payload bytes; each payload byte comes out with its index and the frame
// type, and the request that ends a frame carries the frame report. Lengths of
// zero or above the smaller of max_frame_len and FRAME_LIMIT are dropped with
// a bad length report and header hunting restarts on the next byte. The
// parser state is updated in a single pass per byte and results are
// registered in a two-entry output stage, so o_ready drops only when both
// output entries are full. max_frame_len is written through the config
// channel, which is always ready; write it only while no request is in
// flight. No clearing pass is needed after reset.
module length_prefixed_frame_deframer_top #(
    parameter int FRAME_LIMIT = lfd_pkg::FRAME_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic [11:0] o_payload_index,
    output logic [7:0]  o_frame_type,
    output logic        o_frame_end,
    output logic [2:0]  o_event_code,
    output logic        o_pad_present,
    output logic [31:0] o_frame_length
);

    // payload_left never exceeds FRAME_LIMIT - 1
    localparam int LEFT_W = $clog2(FRAME_LIMIT);
    localparam logic [31:0] LIMIT32 = 32'(FRAME_LIMIT);

    // config register
    logic [12:0] r_max_len;

    // parser state
    lfd_pkg::t_phase r_phase,  n_phase;
    logic [1:0]      r_count,  n_count;
    logic [31:0]     r_accum,  n_accum;
    logic [7:0]      r_type,   n_type;
    logic [LEFT_W-1:0] r_left, n_left;
    logic [11:0]     r_pos,    n_pos;
    logic            r_fzero,  n_fzero;

    logic             accept;
    logic             finish;
    logic [7:0]       fin_type;
    logic             fin_fzero;
    logic [31:0]      limit;
    logic [31:0]      hdr_accum;
    lfd_pkg::t_event  fin_event;
    lfd_pkg::t_result res;
    lfd_pkg::t_result out_data;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;

    // effective limit is the smaller of the register and the build limit
    assign limit = ({19'd0, r_max_len} > LIMIT32) ? LIMIT32 : {19'd0, r_max_len};

    // little-endian length gathering
    assign hdr_accum = r_accum | (32'(i_rx_byte) << {r_count, 3'b000});

    // report chosen by type and payload length at frame end
    always_comb begin
        priority if (fin_type == lfd_pkg::TYPE_INPUT) begin
            fin_event = ((r_accum - 32'd1) == lfd_pkg::INPUT_REPORT_LEN) ?
                        lfd_pkg::EV_INPUT : lfd_pkg::EV_BAD_INPUT;
        end else if (fin_type == lfd_pkg::TYPE_PAD_INFO) begin
            fin_event = ((r_accum - 32'd1) >= lfd_pkg::PAD_INFO_MIN_LEN) ?
                        lfd_pkg::EV_PAD_INFO : lfd_pkg::EV_NONE;
        end else if (fin_type == lfd_pkg::TYPE_PAD_GONE) begin
            fin_event = lfd_pkg::EV_PAD_GONE;
        end else if (fin_type == lfd_pkg::TYPE_CALIB) begin
            fin_event = lfd_pkg::EV_CALIB;
        end else begin
            fin_event = lfd_pkg::EV_IGNORED;
        end
    end

    // next state and result for one request
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_accum   = r_accum;
        n_type    = r_type;
        n_left    = r_left;
        n_pos     = r_pos;
        n_fzero   = r_fzero;
        res       = '0;
        finish    = 1'b0;
        fin_type  = r_type;
        fin_fzero = r_fzero;

        if (i_req_type == lfd_pkg::REQ_LINK_LOST) begin
            // link lost: drop everything, report pad gone without frame end
            n_phase        = lfd_pkg::PH_HEADER;
            n_count        = '0;
            n_accum        = '0;
            n_type         = '0;
            n_left         = '0;
            n_pos          = '0;
            n_fzero        = 1'b0;
            res.event_code = lfd_pkg::EV_PAD_GONE;
        end else begin
            unique case (r_phase)
                lfd_pkg::PH_HEADER: begin
                    n_accum = hdr_accum;
                    n_count = r_count + 2'd1;
                    if (r_count == 2'd3) begin
                        if (hdr_accum == 32'd0 || hdr_accum > limit) begin
                            // bad length: report and hunt again
                            res.frame_end    = 1'b1;
                            res.event_code   = lfd_pkg::EV_BAD_LEN;
                            res.frame_length = hdr_accum;
                            n_accum          = '0;
                        end else begin
                            n_phase = lfd_pkg::PH_TYPE;
                        end
                    end
                end
                lfd_pkg::PH_TYPE: begin
                    n_type    = i_rx_byte;
                    n_left    = LEFT_W'(r_accum - 32'd1);
                    n_pos     = '0;
                    n_fzero   = 1'b0;
                    fin_type  = i_rx_byte;
                    fin_fzero = 1'b0;
                    if (r_accum == 32'd1) begin
                        // empty payload, type byte closes the frame
                        finish = 1'b1;
                    end else begin
                        n_phase = lfd_pkg::PH_PAYLOAD;
                    end
                end
                lfd_pkg::PH_PAYLOAD: begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = i_rx_byte;
                    res.payload_index = r_pos;
                    res.frame_type    = r_type;
                    // index wraps, so the first-byte test sees every wrap too
                    if (r_pos == 12'd0) begin
                        n_fzero = (i_rx_byte == 8'd0);
                    end
                    fin_fzero = n_fzero;
                    n_pos     = r_pos + 12'd1;
                    n_left    = r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        finish = 1'b1;
                    end
                end
                default: begin
                    n_phase = lfd_pkg::PH_HEADER;
                end
            endcase

            if (finish) begin
                res.frame_type   = fin_type;
                res.frame_end    = 1'b1;
                res.event_code   = fin_event;
                res.pad_present  = (fin_event == lfd_pkg::EV_PAD_INFO) && fin_fzero;
                res.frame_length = r_accum;
                n_phase          = lfd_pkg::PH_HEADER;
                n_count          = '0;
                n_accum          = '0;
                n_type           = '0;
                n_left           = '0;
                n_pos            = '0;
                n_fzero          = 1'b0;
            end
        end
    end

    // state register, advances only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lfd_pkg::PH_HEADER;
            r_count <= '0;
            r_accum <= '0;
            r_type  <= '0;
            r_left  <= '0;
            r_pos   <= '0;
            r_fzero <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_accum <= n_accum;
            r_type  <= n_type;
            r_left  <= n_left;
            r_pos   <= n_pos;
            r_fzero <= n_fzero;
        end
    end

    // max_frame_len register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= lfd_pkg::MAX_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_len <= i_cfg_data;
        end
    end

    // output stage decouples request acceptance from result draining
    lfd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (res),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_data)
    );

    assign o_payload_valid = out_data.payload_valid;
    assign o_payload_byte  = out_data.payload_byte;
    assign o_payload_index = out_data.payload_index;
    assign o_frame_type    = out_data.frame_type;
    assign o_frame_end     = out_data.frame_end;
    assign o_event_code    = out_data.event_code;
    assign o_pad_present   = out_data.pad_present;
    assign o_frame_length  = out_data.frame_length;

    a_count_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != 2'd0) |-> (r_phase == lfd_pkg::PH_HEADER))
        else $error("header byte count set outside header phase");

    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lfd_pkg::PH_PAYLOAD) |-> (r_left != '0))
        else $error("payload phase with nothing left");

    a_length_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != lfd_pkg::PH_HEADER) |-> (r_accum != 32'd0 && r_accum <= LIMIT32))
        else $error("frame length out of range past header");

    a_link_lost_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type == lfd_pkg::REQ_LINK_LOST) |=>
        (r_phase == lfd_pkg::PH_HEADER && r_count == 2'd0 && r_accum == 32'd0))
        else $error("link lost did not clear parser state");

endmodule

// ===== rtl/core/lfd_skid.sv =====
`timescale 1ns / 1ps

// two-entry output stage: result register plus skid register
module lfd_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  lfd_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output lfd_pkg::t_result o_data
);

    logic             r_out_valid;
    logic             r_skid_valid;
    lfd_pkg::t_result r_out;
    lfd_pkg::t_result r_skid;
    logic             n_out_valid;
    logic             n_skid_valid;
    logic             push;
    logic             pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign push    = i_valid && !r_skid_valid;
    assign pop     = r_out_valid && i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (pop) begin
            n_out_valid  = r_skid_valid || push;
            n_skid_valid = 1'b0;
        end else if (push) begin
            n_out_valid  = 1'b1;
            n_skid_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (push) begin
                r_out <= i_data;
            end
        end else if (push) begin
            if (r_out_valid) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while result register empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_ready) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid entry lost or changed while stalled");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved into result register");

endmodule
